// ===== rtl/core/tsd_pkg.sv =====
// Shared types, codes and the CRC-8 byte update for the thermometer
// scratchpad decoder. No dependencies.
package tsd_pkg;

  typedef enum logic [1:0] {
    OP_RESET_PRESENT = 2'd0,
    OP_RESET_ABSENT  = 2'd1,
    OP_DATA          = 2'd2,
    OP_UNUSED        = 2'd3
  } op_e;

  // Scratchpad byte positions that carry meaning.
  localparam logic [3:0] BYTE_TEMP_LSB  = 4'd0;
  localparam logic [3:0] BYTE_TEMP_MSB  = 4'd1;
  localparam logic [3:0] BYTE_CONFIG    = 4'd4;
  localparam logic [3:0] BYTE_COUNT_REM = 4'd6;
  localparam logic [3:0] BYTE_COUNT_PER = 4'd7;

  localparam logic [7:0]  CRC_POLY      = 8'h8C;
  localparam logic [7:0]  OLD_PART_MASK = 8'h80;
  localparam logic [7:0]  COUNT_PER_C   = 8'h10;
  localparam logic [15:0] INVALID_TEMP  = 16'h8300;  // -32000
  localparam logic [15:0] EXT_OFFSET    = 16'd4;
  localparam logic [15:0] EXT_COUNT     = 16'd16;

  typedef struct packed {
    op_e        operation;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic               valid_res;
    logic               changed;
    logic               sensor_kind;
  } out_word_t;

  // Frame status from the decoder to the filter and the result register.
  typedef struct packed {
    logic        emit;
    logic        ok;
    logic        kind;
    logic [15:0] raw;
  } close_t;

  // Reflected CRC-8 over one byte, LSB first.
  function automatic logic [7:0] crc_byte(logic [7:0] crc_in, logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b   = data;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

// ===== rtl/core/temp_scratchpad_decoder.sv =====
// Top level of the thermometer scratchpad decoder: input register, frame
// decoder, flutter filter and result register. Depends on tsd_pkg.

// The block takes one word per cycle, a bus-reset event or one of the nine
// scratchpad bytes, and sustains one word per clock while results drain. A
// word is held in the input register; its result, if any, is loaded from
// there into the result register when the result register is free. The
// CRC-8 byte update, temperature assembly and flutter filter all settle
// between those two registers. While a stalled result holds the result
// register, the word behind it waits in the input register and the input
// stalls. A reset without a device and the closing CRC byte each produce
// one result word; every other input produces none.
module temp_scratchpad_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsd_pkg::out_word_t out_word_o
);

  logic               in_valid_q;
  tsd_pkg::in_word_t  in_word_q;
  logic               out_valid_q;
  tsd_pkg::out_word_t out_word_q, out_word_d;
  logic               out_free;
  logic               proc_fire;
  tsd_pkg::close_t    close;
  logic               filt_changed;

  // The held word moves on whenever the result register is empty or drains
  // this cycle, so a result that drains this cycle does not block the next input.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc_fire  = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  tsd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (proc_fire),
    .word_i  (in_word_q),
    .close_o (close)
  );

  tsd_filter u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (proc_fire),
    .close_i   (close),
    .changed_o (filt_changed)
  );

  // A bad frame or a missing device reports the invalid marker; the
  // filter only speaks for good frames.
  always_comb begin
    out_word_d.temperature = close.ok ? $signed(close.raw) : $signed(tsd_pkg::INVALID_TEMP);
    out_word_d.valid_res   = close.ok;
    out_word_d.changed     = close.ok && filt_changed;
    out_word_d.sensor_kind = close.kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= close.emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && close.emit) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/core/tsd_decode.sv =====
// Frame tracker: byte counter, CRC-8 and temperature assembly.
// Depends on tsd_pkg.
module tsd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  tsd_pkg::in_word_t word_i,
  output tsd_pkg::close_t   close_o
);

  logic [3:0]  count_q, count_d;
  logic        active_q, active_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] raw_q, raw_d;
  logic        old_q, old_d;
  logic        cpc_q, cpc_d;
  logic [15:0] halved;

  assign halved = {raw_q[15], raw_q[15:1]};

  always_comb begin
    count_d  = count_q;
    active_d = active_q;
    crc_d    = crc_q;
    raw_d    = raw_q;
    old_d    = old_q;
    cpc_d    = cpc_q;
    close_o      = '0;
    close_o.raw  = raw_q;
    close_o.kind = old_q;
    if (fire_i) begin
      case (word_i.operation)
        tsd_pkg::OP_RESET_PRESENT: begin
          active_d = 1'b1;
          count_d  = '0;
          crc_d    = '0;
          raw_d    = '0;
          old_d    = 1'b0;
          cpc_d    = 1'b0;
        end
        tsd_pkg::OP_RESET_ABSENT: begin
          active_d     = 1'b0;
          close_o.emit = 1'b1;
          close_o.kind = 1'b0;
        end
        tsd_pkg::OP_DATA: begin
          if (active_q) begin
            if (!count_q[3]) begin
              crc_d   = tsd_pkg::crc_byte(crc_q, word_i.data_byte);
              count_d = count_q + 4'd1;
              case (count_q)
                tsd_pkg::BYTE_TEMP_LSB: raw_d = {8'h00, word_i.data_byte};
                tsd_pkg::BYTE_TEMP_MSB: raw_d = raw_q + {word_i.data_byte, 8'h00};
                tsd_pkg::BYTE_CONFIG: begin
                  if ((word_i.data_byte & tsd_pkg::OLD_PART_MASK) != 8'h00) begin
                    raw_d = {halved[11:0], 4'h0} - tsd_pkg::EXT_OFFSET;
                    old_d = 1'b1;
                  end
                end
                tsd_pkg::BYTE_COUNT_REM: begin
                  if (old_q) begin
                    raw_d = raw_q + tsd_pkg::EXT_COUNT - {8'h00, word_i.data_byte};
                  end
                end
                tsd_pkg::BYTE_COUNT_PER: cpc_d = (word_i.data_byte == tsd_pkg::COUNT_PER_C);
                default: ;
              endcase
            end else begin
              // The CRC byte closes the frame.
              active_d     = 1'b0;
              count_d      = '0;
              close_o.emit = 1'b1;
              close_o.ok   = (word_i.data_byte == crc_q) && cpc_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      active_q <= 1'b0;
      crc_q    <= '0;
      raw_q    <= '0;
      old_q    <= 1'b0;
      cpc_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      active_q <= active_d;
      crc_q    <= crc_d;
      raw_q    <= raw_d;
      old_q    <= old_d;
      cpc_q    <= cpc_d;
    end
  end

endmodule

// ===== rtl/core/tsd_filter.sv =====
// Flutter filter holding the reference temperature.
// Depends on tsd_pkg for the frame status type.
module tsd_filter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  tsd_pkg::close_t close_i,
  output logic            changed_o
);

  logic [15:0]        ref_q, ref_d;
  logic signed [16:0] diff;

  assign diff = $signed({ref_q[15], ref_q}) - $signed({close_i.raw[15], close_i.raw});

  always_comb begin
    ref_d     = ref_q;
    changed_o = 1'b0;
    if (diff == 17'sd2) begin
      changed_o = 1'b1;
      ref_d     = ref_q - 16'd1;
    end else if (diff == -17'sd2) begin
      changed_o = 1'b1;
      ref_d     = ref_q + 16'd1;
    end else if (diff == 17'sd0 || diff == 17'sd1 || diff == -17'sd1) begin
      changed_o = 1'b0;
    end else begin
      changed_o = 1'b1;
      ref_d     = close_i.raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (fire_i && close_i.emit && close_i.ok) begin
      ref_q <= ref_d;
    end
  end

endmodule
